// File: hdl/olar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olar_pkg
// Types and codes shared by the ordered list cells, top level and checker.
// ----------------------------------------------------------------------------
package olar_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OccW  = 5;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_READ   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_APPEND = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [DataW-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [DataW-1:0] entry_value;
    logic                    last;
    logic [OccW-1:0]         occupancy;
  } out_rsp_t;

  typedef struct packed {
    cell_op_e          op;
    logic [DataW-1:0]  value;
  } cell_ctrl_t;

  typedef struct packed {
    logic              occ;
    logic [DataW-1:0]  data;
  } cell_link_t;

endpackage

// File: hdl/ordered_list_append_remove_key.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_append_remove_key
// Bounded ordered list held in a chain of cells; append at tail, remove first
// match with gap closing, read out head to tail.
// ----------------------------------------------------------------------------
// append and remove: result registered in the cycle after the request is taken
// one request per cycle unless the output stalls; the key search ripples the chain
// read: in S_READ the chain rotates, one result per cycle unless the output stalls
// the next request is taken once the last read result is registered
// reset clears the entry count and occupied flags; entry data is not reset
module ordered_list_append_remove_key #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  olar_pkg::in_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output olar_pkg::out_rsp_t out_rsp_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

  state_e               state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      remain_q, remain_d;
  logic                 out_valid_q, out_valid_d;
  olar_pkg::out_rsp_t   out_rsp_q, out_rsp_d;
  logic                 out_load;
  logic                 out_free;
  logic                 in_acc;
  logic                 full;
  logic                 found;
  logic [CntW+olar_pkg::OccW-1:0] occ_wide;

  olar_pkg::cell_ctrl_t ctrl;
  olar_pkg::cell_link_t link  [CAPACITY+1];
  logic                 hit   [CAPACITY+1];

  assign link[CAPACITY] = '{occ: 1'b0, data: '0};
  assign hit[0]         = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic prev_occ;
    if (i == 0) begin : g_head
      assign prev_occ = 1'b1;
    end else begin : g_body
      assign prev_occ = link[i-1].occ;
    end
    olar_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .prev_occ_i  (prev_occ),
      .next_i      (link[i+1]),
      .head_data_i (link[0].data),
      .hit_i       (hit[i]),
      .link_o      (link[i]),
      .hit_o       (hit[i+1])
    );
  end

  assign found      = hit[CAPACITY];
  assign full       = (count_q == CntW'(CAPACITY));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign occ_wide   = (CntW + olar_pkg::OccW)'(count_d);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    remain_d   = remain_q;
    out_load   = 1'b0;
    ctrl.op    = olar_pkg::CELL_HOLD;
    ctrl.value = $unsigned(in_req_i.value);
    out_rsp_d.status      = olar_pkg::STATUS_OK;
    out_rsp_d.entry_value = '0;
    out_rsp_d.last        = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_req_i.func)
            olar_pkg::FUNC_APPEND: begin
              out_load = 1'b1;
              if (full) begin
                out_rsp_d.status = olar_pkg::STATUS_FULL;
              end else begin
                ctrl.op = olar_pkg::CELL_APPEND;
                count_d = count_q + 1'b1;
              end
            end
            olar_pkg::FUNC_REMOVE: begin
              out_load = 1'b1;
              if (count_q == '0) begin
                out_rsp_d.status = olar_pkg::STATUS_EMPTY;
              end else if (found) begin
                ctrl.op = olar_pkg::CELL_REMOVE;
                count_d = count_q - 1'b1;
              end else begin
                out_rsp_d.status = olar_pkg::STATUS_NOT_FOUND;
              end
            end
            olar_pkg::FUNC_READ: begin
              if (count_q == '0) begin
                out_load         = 1'b1;
                out_rsp_d.status = olar_pkg::STATUS_EMPTY;
              end else begin
                remain_d = count_q;
                state_d  = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_rsp_d.entry_value = $signed(link[0].data);
          out_rsp_d.last        = (remain_q == CntW'(1));
          ctrl.op               = olar_pkg::CELL_ROTATE;
          remain_d              = remain_q - 1'b1;
          if (remain_q == CntW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_rsp_d.occupancy = occ_wide[olar_pkg::OccW-1:0];
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rsp_q <= out_rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// File: hdl/olar_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olar_cell
// One list slot: holds an entry and its occupied flag, matches the key, takes
// data from the tail-side cell on removal or rotation; the tail takes the head.
// ----------------------------------------------------------------------------
module olar_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  olar_pkg::cell_ctrl_t    ctrl_i,
  input  logic                    prev_occ_i,
  input  olar_pkg::cell_link_t    next_i,
  input  logic [olar_pkg::DataW-1:0] head_data_i,
  input  logic                    hit_i,
  output olar_pkg::cell_link_t    link_o,
  output logic                    hit_o
);

  logic                         occ_q, occ_d;
  logic [olar_pkg::DataW-1:0]   data_q, data_d;
  logic                         match;
  logic                         tail;

  assign match  = occ_q && (data_q == ctrl_i.value);
  assign hit_o  = hit_i || match;
  assign tail   = occ_q && !next_i.occ;
  assign link_o = '{occ: occ_q, data: data_q};

  always_comb begin
    occ_d  = occ_q;
    data_d = data_q;
    case (ctrl_i.op)
      olar_pkg::CELL_APPEND: begin
        if (prev_occ_i && !occ_q) begin
          occ_d  = 1'b1;
          data_d = ctrl_i.value;
        end
      end
      olar_pkg::CELL_REMOVE: begin
        if (hit_o) begin
          occ_d  = next_i.occ;
          data_d = next_i.data;
        end
      end
      olar_pkg::CELL_ROTATE: begin
        if (tail) begin
          data_d = head_data_i;
        end else if (occ_q) begin
          data_d = next_i.data;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// File: hdl/olar_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olar_checker
// Port-level checks on the ordered list, bound to the top level.
// ----------------------------------------------------------------------------
module olar_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input olar_pkg::out_rsp_t out_rsp_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_rsp_o)))
    else $error("stalled result changed");

  // no new request while a result is blocked
  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("request taken while result blocked");

  // error results carry no entry and close the request
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.status != olar_pkg::STATUS_OK))
      |-> (out_rsp_o.entry_value == '0 && out_rsp_o.last))
    else $error("error result with entry or without last");

  // full only at capacity, empty only at zero
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status == olar_pkg::STATUS_FULL)
      |-> (out_rsp_o.occupancy == olar_pkg::OccW'(CAPACITY)))
    else $error("full status below capacity");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status == olar_pkg::STATUS_EMPTY)
      |-> (out_rsp_o.occupancy == '0))
    else $error("empty status with entries held");

endmodule

bind ordered_list_append_remove_key olar_checker #(.CAPACITY(CAPACITY)) u_olar_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);
